// ----- hw/rtl/mtc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types, character codes and the Morse code table for the codec.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int MAX_CODE_SYMBOLS_DEF = 5;  // default token symbol limit
  localparam int MAX_CODE_SYMBOLS_TOP = 8;  // largest supported limit
  localparam int TBL_LEN_W            = 4;  // length width at the table lookup
  localparam int TBL_PAT_W            = 8;  // pattern width at the table lookup
  localparam int CODE_SYM_MAX         = 5;  // longest code in the table
  localparam int NUM_CODES            = 36; // letters and digits

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // one code: dash = 1, first symbol in bit len-1
  typedef struct packed {
    logic [7:0] sym;
    logic [2:0] len;
    logic [4:0] pat;
  } code_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] len;
    logic [4:0] pat;
  } enc_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] sym;
  } dec_t;

  // work item for the output sequencer
  typedef struct packed {
    logic       slash;  // emit '/' first
    logic [2:0] pend;   // dots/dashes still to send
    logic [4:0] pat;    // next symbol in bit 4
    logic [7:0] fin;    // closing character
  } job_t;

  localparam code_t CODE_TABLE [NUM_CODES] = '{
    '{"A", 3'd2, 5'b00001}, '{"B", 3'd4, 5'b01000}, '{"C", 3'd4, 5'b01010},
    '{"D", 3'd3, 5'b00100}, '{"E", 3'd1, 5'b00000}, '{"F", 3'd4, 5'b00010},
    '{"G", 3'd3, 5'b00110}, '{"H", 3'd4, 5'b00000}, '{"I", 3'd2, 5'b00000},
    '{"J", 3'd4, 5'b00111}, '{"K", 3'd3, 5'b00101}, '{"L", 3'd4, 5'b00100},
    '{"M", 3'd2, 5'b00011}, '{"N", 3'd2, 5'b00010}, '{"O", 3'd3, 5'b00111},
    '{"P", 3'd4, 5'b00110}, '{"Q", 3'd4, 5'b01101}, '{"R", 3'd3, 5'b00010},
    '{"S", 3'd3, 5'b00000}, '{"T", 3'd1, 5'b00001}, '{"U", 3'd3, 5'b00001},
    '{"V", 3'd4, 5'b00001}, '{"W", 3'd3, 5'b00011}, '{"X", 3'd4, 5'b01001},
    '{"Y", 3'd4, 5'b01011}, '{"Z", 3'd4, 5'b01100}, '{"0", 3'd5, 5'b11111},
    '{"1", 3'd5, 5'b01111}, '{"2", 3'd5, 5'b00111}, '{"3", 3'd5, 5'b00011},
    '{"4", 3'd5, 5'b00001}, '{"5", 3'd5, 5'b00000}, '{"6", 3'd5, 5'b10000},
    '{"7", 3'd5, 5'b11000}, '{"8", 3'd5, 5'b11100}, '{"9", 3'd5, 5'b11110}
  };

  function automatic enc_t encode_char(input logic [7:0] c);
    enc_t r;
    r = '0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (CODE_TABLE[i].sym == c) begin
        r.hit = 1'b1;
        r.len = CODE_TABLE[i].len;
        r.pat = CODE_TABLE[i].pat;
      end
    end
    return r;
  endfunction

  function automatic dec_t decode_token(input logic [TBL_LEN_W-1:0] len,
                                        input logic [TBL_PAT_W-1:0] pat);
    dec_t r;
    r = '0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (len == {1'b0, CODE_TABLE[i].len} && pat == {3'b000, CODE_TABLE[i].pat}) begin
        r.hit = 1'b1;
        r.sym = CODE_TABLE[i].sym;
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/morse_text_codec_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_text_codec_core
// ASCII <-> International Morse converter, one byte per input transfer.
// ----------------------------------------------------------------------------
// Path: an input byte passes the token RAM read stage and then the output job register.
// Throughput: decode bytes one per cycle while the sequencer takes jobs; an encoded byte
//   sends 2 to 6 characters (symbols + trailing space); a new job loads on the last transfer.
// Token record: one-entry RAM, read on accept, written back when the decode item advances,
//   forwarded for back-to-back decode bytes.
// Reset: asynchronous, active low; clears all valid flags, token reads empty until written.
module morse_text_codec_core #(
  parameter int MAX_CODE_SYMBOLS = mtc_pkg::MAX_CODE_SYMBOLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_text_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o
);

  logic          job_valid;
  logic          job_ready;
  mtc_pkg::job_t job;

  // Stage 1: token read-modify-write and job build
  mtc_token #(
    .MAX_CODE_SYMBOLS (MAX_CODE_SYMBOLS)
  ) u_token (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .in_char_i     (in_char_i),
    .end_of_text_i (end_of_text_i),
    .job_valid_o   (job_valid),
    .job_ready_i   (job_ready),
    .job_o         (job)
  );

  // Stage 2: one character per output transfer
  mtc_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_ready_o   (job_ready),
    .job_i         (job),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- hw/rtl/mtc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_ram
// Generic single-write, single-read RAM with registered read (read-old).
// ----------------------------------------------------------------------------
module mtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/mtc_token.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_token
// Input stage: reads the decode token from RAM, updates it, writes it back
// and builds the output job for encode or decode.
// ----------------------------------------------------------------------------
module mtc_token #(
  parameter int MAX_CODE_SYMBOLS = mtc_pkg::MAX_CODE_SYMBOLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [7:0]        in_char_i,
  input  logic              end_of_text_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output mtc_pkg::job_t     job_o
);

  localparam int LW    = $clog2(MAX_CODE_SYMBOLS + 1);
  localparam int TOK_W = MAX_CODE_SYMBOLS + LW + 2;

  // token record: {malformed, slash, length, pattern}
  logic                        s1_valid_q;
  logic                        s1_action_q;
  logic [7:0]                  s1_char_q;
  logic                        s1_eot_q;
  logic                        use_fwd_q, have_q, written_q;
  logic [TOK_W-1:0]            fwd_q, rd_data, cur, wr_data;
  logic                        accept, advance, wr_en, has_job;

  logic [MAX_CODE_SYMBOLS-1:0] pat;
  logic [LW-1:0]               len;
  logic                        mal, sl, blank, ends;
  mtc_pkg::dec_t               dec;
  mtc_pkg::enc_t               enc;
  logic [7:0]                  c_up;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !advance;
  assign advance    = s1_valid_q && (!has_job || job_ready_i);
  assign wr_en      = advance && (s1_action_q == mtc_pkg::ACT_DECODE);
  assign job_valid_o = s1_valid_q && has_job;

  mtc_ram #(
    .WIDTH (TOK_W),
    .DEPTH (1)
  ) u_tok_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (1'b0),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (1'b0),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      written_q  <= 1'b0;
      use_fwd_q  <= 1'b0;
      have_q     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        use_fwd_q  <= wr_en;     // read at this edge returns the old word
        have_q     <= written_q;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        written_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= action_i;
      s1_char_q   <= in_char_i;
      s1_eot_q    <= end_of_text_i;
    end
    if (wr_en) begin
      fwd_q <= wr_data;
    end
  end

  // never-written entry reads as the reset token
  assign cur = use_fwd_q ? fwd_q : (have_q ? rd_data : '0);

  always_comb begin
    pat   = cur[MAX_CODE_SYMBOLS-1:0];
    len   = cur[MAX_CODE_SYMBOLS +: LW];
    sl    = cur[TOK_W-2];
    mal   = cur[TOK_W-1];
    blank = (s1_char_q == mtc_pkg::CH_SPACE) ||
            (s1_char_q >= mtc_pkg::CH_TAB && s1_char_q <= mtc_pkg::CH_CR);

    if (!blank) begin
      if (s1_char_q == mtc_pkg::CH_DOT || s1_char_q == mtc_pkg::CH_DASH) begin
        if (sl || len >= LW'(MAX_CODE_SYMBOLS)) begin
          mal = 1'b1;
        end else begin
          pat = {pat[MAX_CODE_SYMBOLS-2:0], s1_char_q == mtc_pkg::CH_DASH};
          len = len + 1'b1;
        end
      end else if (s1_char_q == mtc_pkg::CH_SLASH) begin
        if (len != '0 || sl) begin
          mal = 1'b1;
        end else begin
          sl = 1'b1;
        end
      end else begin
        mal = 1'b1;
      end
    end

    ends = blank || s1_eot_q;
    dec  = mtc_pkg::decode_token(mtc_pkg::TBL_LEN_W'(len), mtc_pkg::TBL_PAT_W'(pat));
    if (mal) begin
      dec.hit = 1'b0;
    end else if (sl && len == '0) begin
      dec.hit = 1'b1;
      dec.sym = mtc_pkg::CH_SPACE;
    end else if (len == '0) begin
      dec.hit = 1'b0;
    end

    wr_data = ends ? '0 : {mal, sl, len, pat};

    // encode side
    c_up = s1_char_q;
    if (s1_char_q >= mtc_pkg::CH_LOW_A && s1_char_q <= mtc_pkg::CH_LOW_Z) begin
      c_up = s1_char_q - mtc_pkg::CASE_GAP;
    end
    enc = mtc_pkg::encode_char(c_up);

    job_o = '0;
    if (s1_action_q == mtc_pkg::ACT_ENCODE) begin
      job_o.fin = mtc_pkg::CH_SPACE;
      if (c_up == mtc_pkg::CH_SPACE) begin
        has_job     = 1'b1;
        job_o.slash = 1'b1;
      end else begin
        has_job   = enc.hit;
        job_o.pend = enc.len;
        job_o.pat  = enc.pat << (3'(mtc_pkg::CODE_SYM_MAX) - enc.len);
      end
    end else begin
      has_job   = ends && dec.hit;
      job_o.fin = dec.sym;
    end
  end

`ifndef SYNTHESIS
  a_wr_only_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s1_valid_q && s1_action_q == mtc_pkg::ACT_DECODE)
    else $error("token write without a decode item");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> wr_data[MAX_CODE_SYMBOLS +: LW] <= LW'(MAX_CODE_SYMBOLS))
    else $error("token length over limit");
  a_fwd_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> $stable(use_fwd_q) && (!use_fwd_q || $stable(fwd_q)))
    else $error("forwarded token changed while stalled");
`endif

endmodule

// ----- hw/rtl/mtc_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_emit
// Output sequencer: holds one job and sends its characters, one per transfer.
// ----------------------------------------------------------------------------
module mtc_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  mtc_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_char_o,
  output logic          last_of_run_o
);

  logic          job_valid_q;
  mtc_pkg::job_t job_q;
  logic          fire, load;

  assign fire          = job_valid_q && !out_stall_i;
  assign last_of_run_o = !job_q.slash && job_q.pend == '0;
  assign job_ready_o   = !job_valid_q || (fire && last_of_run_o);
  assign load          = job_valid_i && job_ready_o;
  assign out_valid_o   = job_valid_q;

  always_comb begin
    if (job_q.slash) begin
      out_char_o = mtc_pkg::CH_SLASH;
    end else if (job_q.pend != '0) begin
      out_char_o = job_q.pat[4] ? mtc_pkg::CH_DASH : mtc_pkg::CH_DOT;
    end else begin
      out_char_o = job_q.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (load) begin
      job_valid_q <= 1'b1;
    end else if (fire && last_of_run_o) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end else if (fire) begin
      if (job_q.slash) begin
        job_q.slash <= 1'b0;
      end else if (job_q.pend != '0) begin
        job_q.pend <= job_q.pend - 1'b1;
        job_q.pat  <= {job_q.pat[3:0], 1'b0};
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_q.pend <= 3'(mtc_pkg::CODE_SYM_MAX))
    else $error("symbol count over code length");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_of_run_o && !load) |=> !job_valid_q)
    else $error("job stays after final transfer");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !last_of_run_o) |-> !load)
    else $error("job loaded over unfinished job");
`endif

endmodule
